FILE: design/rshs_pkg.sv
// Shared types and constants for the racket serve and hit sequencer.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rshs_pkg;

    // Opcodes carried in s_axis_tuser
    localparam logic [2:0] OP_UPDATE    = 3'd0;
    localparam logic [2:0] OP_SERVE     = 3'd1;
    localparam logic [2:0] OP_HIT       = 3'd2;
    localparam logic [2:0] OP_STOP      = 3'd3;
    localparam logic [2:0] OP_LOCK      = 3'd4;
    localparam logic [2:0] OP_CALIBRATE = 3'd5;
    localparam logic [2:0] OP_HIT_ON    = 3'd6;
    localparam logic [2:0] OP_HIT_OFF   = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_HIT_VELOCITY  = 2'd0;
    localparam logic [1:0] REG_CAL_VELOCITY  = 2'd1;
    localparam logic [1:0] REG_SERVE_DELAY   = 2'd2;

    // Configuration reset values
    localparam logic signed [15:0] HIT_VELOCITY_RST = -16'sd1300;
    localparam logic signed [15:0] CAL_VELOCITY_RST = 16'sd500;
    localparam logic [31:0]        SERVE_DELAY_RST  = 32'd510;

    // Servo pulse codes
    localparam logic [10:0] PULSE_RELEASE = 11'd1500;
    localparam logic [10:0] PULSE_RETURN  = 11'd900;

    // Encoder margin added to hit velocity for the hit-end threshold
    localparam logic signed [31:0] HIT_MARGIN = 32'sd2000;

    // Encoder capture value out of reset
    localparam logic signed [31:0] CAPTURE_RST = -32'sd5000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [31:0]        now_ticks;
        logic signed [31:0] encoder_value;
        logic               racket_limit;
        logic               rotate_limit;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] motor_velocity;
        logic               closed_loop;
        logic               motor_write;
        logic               accel_write;
        logic               servo_write;
        logic [10:0]        servo_pulse;
        logic               locked_status;
        logic               hit_active;
        logic               serve_waiting;
        logic signed [31:0] start_encoder;
    } result_t;

    typedef struct packed {
        logic signed [15:0] hit_velocity;
        logic signed [15:0] calibrate_velocity;
        logic [31:0]        serve_delay;
    } cfg_t;

endpackage

`default_nettype wire

FILE: design/racket_serve_hit_sequencer.sv
// Racket serve and hit sequencer, top level: config registers, input register,
// sequencer core and result register. Depends on rshs_pkg, rshs_in_stage,
// rshs_core and rshs_out_stage.
//
// Slave stream: one command per transfer; s_axis_tuser holds the opcode,
//   s_axis_tdata the tick time, encoder reading and both limit switches.
// Master stream: exactly one result per command, in command order: motor velocity
//   and loop mode, write strobes, servo pulse, status flags, captured encoder.
// Config port: cfg_wr_en writes cfg_data into register cfg_index (0 hit velocity, 1 calibrate
//   velocity, 2 serve delay, 3 ignored); user to write only while nothing is in flight (unchecked).
// Timing: a command taken at one edge sits in the input register; once the result
//   register has room its result moves there and m_axis_tvalid rises. One command per
//   cycle sustained while m_axis_tready stays high; the single pass of next-state logic
//   (32-bit serve-time add and compare, encoder compare) sits between the two registers.
// Reset: rst_n clears both valid flags and the sequencer state (open loop,
//   velocity 0, unlocked, servo home, no serve pending, capture -5000) and
//   restores the config defaults.
// Stall: while m_axis_tready is low the result holds, one more command may be
//   taken into the input register, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module racket_serve_hit_sequencer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // now_ticks[31:0], encoder_value[63:32],
                                            // racket_limit[64], rotate_limit[65], zero
    input  wire logic [2:0]  s_axis_tuser,  // opcode[2:0]
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // motor_velocity[15:0], closed_loop[16],
                                            // motor_write[17], accel_write[18],
                                            // servo_write[19], servo_pulse[30:20],
                                            // locked_status[31], hit_active[32],
                                            // serve_waiting[33], start_encoder[65:34], zero
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    rshs_pkg::cfg_t     cfg_reg;
    rshs_pkg::cfg_t     cfg_next;
    rshs_pkg::in_item_t in_item;
    rshs_pkg::in_item_t item;
    rshs_pkg::result_t  result;
    rshs_pkg::result_t  result_q;
    logic               room;
    logic               step;

    // config register file, write only
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rshs_pkg::REG_HIT_VELOCITY: cfg_next.hit_velocity       = cfg_data[15:0];
                rshs_pkg::REG_CAL_VELOCITY: cfg_next.calibrate_velocity = cfg_data[15:0];
                rshs_pkg::REG_SERVE_DELAY:  cfg_next.serve_delay        = cfg_data;
                default:                    cfg_next = cfg_reg;     // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_velocity       <= rshs_pkg::HIT_VELOCITY_RST;
            cfg_reg.calibrate_velocity <= rshs_pkg::CAL_VELOCITY_RST;
            cfg_reg.serve_delay        <= rshs_pkg::SERVE_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack slave payload
    assign in_item.opcode        = s_axis_tuser;
    assign in_item.now_ticks     = s_axis_tdata[31:0];
    assign in_item.encoder_value = s_axis_tdata[63:32];
    assign in_item.racket_limit  = s_axis_tdata[64];
    assign in_item.rotate_limit  = s_axis_tdata[65];

    rshs_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .room     (room),
        .step     (step),
        .item     (item)
    );

    rshs_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    rshs_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (result),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result_out (result_q)
    );

    // pack master payload
    assign m_axis_tdata[15:0]  = result_q.motor_velocity;
    assign m_axis_tdata[16]    = result_q.closed_loop;
    assign m_axis_tdata[17]    = result_q.motor_write;
    assign m_axis_tdata[18]    = result_q.accel_write;
    assign m_axis_tdata[19]    = result_q.servo_write;
    assign m_axis_tdata[30:20] = result_q.servo_pulse;
    assign m_axis_tdata[31]    = result_q.locked_status;
    assign m_axis_tdata[32]    = result_q.hit_active;
    assign m_axis_tdata[33]    = result_q.serve_waiting;
    assign m_axis_tdata[65:34] = result_q.start_encoder;
    assign m_axis_tdata[71:66] = '0;

endmodule

`default_nettype wire

FILE: design/rshs_in_stage.sv
// Input register of the sequencer: captures one transfer from the slave side.
// Depends on rshs_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module rshs_in_stage
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rshs_pkg::in_item_t in_item,
    input  wire logic             room,     // result register can take an item
    output logic                  step,     // held item moves on this cycle
    output rshs_pkg::in_item_t    item
);

    logic               valid_reg;
    logic               valid_next;
    rshs_pkg::in_item_t item_reg;

    assign step     = valid_reg && room;
    assign in_ready = !valid_reg || room;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/rshs_core.sv
// Sequencer state and the per-item next-state / result logic.
// Depends on rshs_pkg for opcodes, constants and item/result/config types.
`timescale 1ns / 1ps
`default_nettype none

module rshs_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire rshs_pkg::in_item_t item,
    input  wire rshs_pkg::cfg_t     cfg,
    output rshs_pkg::result_t       result
);

    logic signed [15:0] velocity_reg,  velocity_next;
    logic               closed_reg,    closed_next;
    logic               hit_reg,       hit_next;
    logic               locked_reg,    locked_next;
    logic               released_reg,  released_next;
    logic               pending_reg,   pending_next;
    logic [31:0]        serve_start_reg, serve_start_next;
    logic signed [31:0] capture_reg,   capture_next;

    logic               motor_wr;
    logic               accel_wr;
    logic               servo_wr;
    logic [10:0]        pulse;
    logic [31:0]        serve_due;
    logic signed [31:0] threshold;
    logic               switch_hit;

    assign serve_due  = cfg.serve_delay + serve_start_reg;   // wraps mod 2^32
    assign threshold  = {{16{cfg.hit_velocity[15]}}, cfg.hit_velocity} + rshs_pkg::HIT_MARGIN;
    assign switch_hit = item.racket_limit || item.rotate_limit;

    always_comb
    begin
        velocity_next    = velocity_reg;
        closed_next      = closed_reg;
        hit_next         = hit_reg;
        locked_next      = locked_reg;
        released_next    = released_reg;
        pending_next     = pending_reg;
        serve_start_next = serve_start_reg;
        capture_next     = capture_reg;
        motor_wr         = 1'b0;
        accel_wr         = 1'b0;
        servo_wr         = 1'b0;
        pulse            = '0;

        unique case (item.opcode)
            rshs_pkg::OP_UPDATE:
            begin
                // serve timer expiry: automatic hit (calibrate velocity when unlocked) plus servo toggle
                if (pending_reg && (item.now_ticks > serve_due))
                begin
                    pending_next = 1'b0;
                    closed_next  = 1'b0;
                    if (locked_reg)
                    begin
                        capture_next  = item.encoder_value;
                        locked_next   = 1'b0;
                        hit_next      = 1'b1;
                        velocity_next = cfg.hit_velocity;
                    end
                    else
                    begin
                        hit_next      = 1'b0;
                        velocity_next = cfg.calibrate_velocity;
                    end
                    servo_wr      = 1'b1;
                    pulse         = released_reg ? rshs_pkg::PULSE_RETURN
                                                 : rshs_pkg::PULSE_RELEASE;
                    released_next = !released_reg;
                end
                // hit ends on encoder travel; otherwise a switch locks when idle
                if (hit_next && (item.encoder_value > threshold))
                begin
                    accel_wr      = 1'b1;
                    hit_next      = 1'b0;
                    velocity_next = '0;
                    closed_next   = 1'b1;
                end
                else if (switch_hit && !hit_next)
                begin
                    locked_next   = 1'b1;
                    velocity_next = '0;
                    closed_next   = 1'b1;
                end
                motor_wr = 1'b1;
            end
            rshs_pkg::OP_SERVE:
            begin
                if (!released_reg)
                begin
                    servo_wr         = 1'b1;
                    pulse            = rshs_pkg::PULSE_RELEASE;
                    released_next    = 1'b1;
                    serve_start_next = item.now_ticks;
                    pending_next     = 1'b1;
                end
            end
            rshs_pkg::OP_HIT:
            begin
                closed_next = 1'b0;
                if (locked_reg)
                begin
                    capture_next  = item.encoder_value;
                    locked_next   = 1'b0;
                    hit_next      = 1'b1;
                    velocity_next = cfg.hit_velocity;
                end
                else
                begin
                    hit_next      = 1'b0;
                    velocity_next = cfg.calibrate_velocity;
                end
            end
            rshs_pkg::OP_STOP:
            begin
                hit_next      = 1'b0;
                locked_next   = 1'b0;
                velocity_next = '0;
                closed_next   = 1'b0;
            end
            rshs_pkg::OP_LOCK:
            begin
                hit_next      = 1'b0;
                velocity_next = '0;
                closed_next   = 1'b1;
            end
            rshs_pkg::OP_CALIBRATE:
            begin
                hit_next      = 1'b0;
                velocity_next = cfg.calibrate_velocity;
                closed_next   = 1'b0;
            end
            rshs_pkg::OP_HIT_ON:
            begin
                hit_next = 1'b1;
            end
            rshs_pkg::OP_HIT_OFF:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.motor_velocity = velocity_next;
        result.closed_loop    = closed_next;
        result.motor_write    = motor_wr;
        result.accel_write    = accel_wr;
        result.servo_write    = servo_wr;
        result.servo_pulse    = pulse;
        result.locked_status  = locked_next;
        result.hit_active     = hit_next;
        result.serve_waiting  = pending_next;
        result.start_encoder  = capture_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg    <= '0;
            closed_reg      <= 1'b0;
            hit_reg         <= 1'b0;
            locked_reg      <= 1'b0;
            released_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            serve_start_reg <= '0;
            capture_reg     <= rshs_pkg::CAPTURE_RST;
        end
        else if (step)
        begin
            velocity_reg    <= velocity_next;
            closed_reg      <= closed_next;
            hit_reg         <= hit_next;
            locked_reg      <= locked_next;
            released_reg    <= released_next;
            pending_reg     <= pending_next;
            serve_start_reg <= serve_start_next;
            capture_reg     <= capture_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/rshs_out_stage.sv
// Result register of the sequencer: holds one result until the master side takes it.
// Depends on rshs_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module rshs_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire rshs_pkg::result_t result_in,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rshs_pkg::result_t      result_out
);

    logic              valid_reg;
    logic              valid_next;
    rshs_pkg::result_t result_reg;

    assign room       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

FILE: design/rshs_checker.sv
// Port-level checks for racket_serve_hit_sequencer, attached with bind.
// Depends on the top level's ports and rshs_pkg for the servo pulse codes.
`timescale 1ns / 1ps
`default_nettype none

module rshs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);

    logic signed [15:0] velocity;
    logic               closed;
    logic               motor_wr;
    logic               accel_wr;
    logic               servo_wr;
    logic [10:0]        pulse;
    logic               hit_active;

    assign velocity   = m_axis_tdata[15:0];
    assign closed     = m_axis_tdata[16];
    assign motor_wr   = m_axis_tdata[17];
    assign accel_wr   = m_axis_tdata[18];
    assign servo_wr   = m_axis_tdata[19];
    assign pulse      = m_axis_tdata[30:20];
    assign hit_active = m_axis_tdata[32];

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // servo pulse is a valid code exactly when a servo command is issued
    a_servo_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (servo_wr ? (pulse == rshs_pkg::PULSE_RELEASE ||
                                       pulse == rshs_pkg::PULSE_RETURN)
                                    : (pulse == 11'd0)))
        else $error("servo pulse inconsistent with servo write");

    // hit end only on an update, leaving the motor held closed loop
    a_hit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && accel_wr) |->
            (motor_wr && closed && !hit_active && velocity == 16'sd0))
        else $error("accel write without hit-end state");

    // closed loop always commands zero velocity
    a_closed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && closed) |-> (velocity == 16'sd0))
        else $error("closed loop with nonzero velocity");

endmodule

bind racket_serve_hit_sequencer rshs_checker u_rshs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
